### hdl/lookup3_byte_stream_hash_defines.svh
// Assertion macros shared by the hash block.
`ifndef LOOKUP3_BYTE_STREAM_HASH_DEFINES_SVH
`define LOOKUP3_BYTE_STREAM_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define LK3H_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lk3h: same-cycle check failed");
`define LK3H_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lk3h: next-cycle check failed");
`else
`define LK3H_ASSERT_IMP(label, clk, rst, ante, cons)
`define LK3H_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### hdl/lk3h_pkg.sv
package lk3h_pkg;

   localparam logic [31:0] SEED_BASE = 32'hDEADBEEF;
   localparam int BLOCK_BYTES = 12;
   localparam int BLOCK_BITS = 8 * BLOCK_BYTES;
   localparam int CNT_W = 4;
   localparam int BMIX_STEPS = 6;
   localparam int FMIX_STEPS = 7;
   localparam int STEP_W = 3;
   // Up to seven jobs can pile up behind one block mix at full input rate.
   localparam int QUEUE_DEPTH_DEFAULT = 8;

   typedef enum logic [1:0] {
      JOB_MIX,
      JOB_FINAL,
      JOB_EMPTY
   } job_kind_type;

   // One unit of work for the back end: a block of up to twelve bytes.
   typedef struct packed {
      job_kind_type kind;
      logic load_seed;
      logic [31:0] seed;
      logic [BLOCK_BITS-1:0] block;
   } job_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
   } abc_type;

   typedef struct packed {
      logic skip;
      abc_type abc;
   } fin_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
      return (v << r) | (v >> (32 - r));
   endfunction

   // One round of the block mix; each round changes two words.
   function automatic abc_type bmix_step(input abc_type s, input logic [STEP_W-1:0] idx);
      abc_type r;
      r = s;
      unique case (idx)
         3'd0: begin
            r.a = (s.a - s.c) ^ rotl(s.c, 4);
            r.c = s.c + s.b;
         end
         3'd1: begin
            r.b = (s.b - s.a) ^ rotl(s.a, 6);
            r.a = s.a + s.c;
         end
         3'd2: begin
            r.c = (s.c - s.b) ^ rotl(s.b, 8);
            r.b = s.b + s.a;
         end
         3'd3: begin
            r.a = (s.a - s.c) ^ rotl(s.c, 16);
            r.c = s.c + s.b;
         end
         3'd4: begin
            r.b = (s.b - s.a) ^ rotl(s.a, 19);
            r.a = s.a + s.c;
         end
         3'd5: begin
            r.c = (s.c - s.b) ^ rotl(s.b, 4);
            r.b = s.b + s.a;
         end
         default: r = s;
      endcase
      return r;
   endfunction

   // One round of the final mix; each round changes one word.
   function automatic abc_type fmix_step(input abc_type s, input logic [STEP_W-1:0] idx);
      abc_type r;
      r = s;
      unique case (idx)
         3'd0: r.c = (s.c ^ s.b) - rotl(s.b, 14);
         3'd1: r.a = (s.a ^ s.c) - rotl(s.c, 11);
         3'd2: r.b = (s.b ^ s.a) - rotl(s.a, 25);
         3'd3: r.c = (s.c ^ s.b) - rotl(s.b, 16);
         3'd4: r.a = (s.a ^ s.c) - rotl(s.c, 4);
         3'd5: r.b = (s.b ^ s.a) - rotl(s.a, 14);
         3'd6: r.c = (s.c ^ s.b) - rotl(s.b, 24);
         default: r = s;
      endcase
      return r;
   endfunction

endpackage

### hdl/lk3h_req_if.sv
interface lk3h_req_if;
   logic valid;
   logic ready;
   logic [7:0] byte_value;
   logic [31:0] message_length;
   logic is_last;

   modport source(output valid, output byte_value, output message_length, output is_last,
      input ready);
   modport sink(input valid, input byte_value, input message_length, input is_last,
      output ready);
endinterface

### hdl/lk3h_rsp_if.sv
interface lk3h_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] hash_value;

   modport source(output valid, output hash_value, input ready);
   modport sink(input valid, input hash_value, output ready);
endinterface

### hdl/lk3h_front.sv
`include "lookup3_byte_stream_hash_defines.svh"
module lk3h_front (
   input logic clock,
   input logic reset,
   lk3h_req_if.sink req_bus,
   output logic push,
   output lk3h_pkg::job_type push_data,
   input logic queue_full
);
   import lk3h_pkg::*;

   logic in_msg_ff, in_msg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [31:0] seed_ff, seed_in;
   logic seed_pend_ff, seed_pend_in;

   logic accept;
   logic first;
   logic is_empty;
   logic [31:0] seed_now;
   logic [CNT_W-1:0] cur_cnt;
   logic [BLOCK_BITS-1:0] cur_blk;
   logic [BLOCK_BITS-1:0] new_blk;

   assign req_bus.ready = !queue_full;
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      first = !in_msg_ff;
      seed_now = SEED_BASE + req_bus.message_length;
      cur_cnt = first ? '0 : cnt_ff;
      cur_blk = first ? '0 : blk_ff;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         new_blk[8*i +: 8] = (cur_cnt == CNT_W'(i)) ? req_bus.byte_value : cur_blk[8*i +: 8];
      end
      is_empty = first && (req_bus.message_length == '0) && req_bus.is_last;

      push = 1'b0;
      push_data.kind = JOB_MIX;
      push_data.load_seed = first || seed_pend_ff;
      push_data.seed = first ? seed_now : seed_ff;
      push_data.block = new_blk;

      in_msg_in = in_msg_ff;
      cnt_in = cnt_ff;
      blk_in = blk_ff;
      seed_in = seed_ff;
      seed_pend_in = seed_pend_ff;

      if (accept) begin
         push = 1'b1;
         priority if (is_empty) begin
            push_data.kind = JOB_EMPTY;
            push_data.block = '0;
         end else if (req_bus.is_last) begin
            push_data.kind = JOB_FINAL;
            in_msg_in = 1'b0;
            cnt_in = '0;
            blk_in = '0;
            seed_pend_in = 1'b0;
         end else if (cur_cnt == CNT_W'(BLOCK_BYTES - 1)) begin
            // A full block followed by more bytes goes to the block mix.
            push_data.kind = JOB_MIX;
            in_msg_in = 1'b1;
            cnt_in = '0;
            blk_in = '0;
            seed_pend_in = 1'b0;
         end else begin
            push = 1'b0;
            in_msg_in = 1'b1;
            cnt_in = cur_cnt + 1'b1;
            blk_in = new_blk;
            seed_in = push_data.seed;
            seed_pend_in = push_data.load_seed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         cnt_ff <= '0;
         seed_pend_ff <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
         cnt_ff <= cnt_in;
         seed_pend_ff <= seed_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      seed_ff <= seed_in;
   end

   `LK3H_ASSERT_IMP(a_cnt_range, clock, reset, in_msg_ff, cnt_ff < CNT_W'(BLOCK_BYTES))
   `LK3H_ASSERT_NXT(a_seed_sent_once, clock, reset, push, !seed_pend_ff)

endmodule

### hdl/lk3h_queue.sv
`include "lookup3_byte_stream_hash_defines.svh"
module lk3h_queue #(
   parameter int DEPTH = lk3h_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic push,
   input lk3h_pkg::job_type push_data,
   output logic full,
   input logic pop,
   output lk3h_pkg::job_type head,
   output logic empty
);
   import lk3h_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   assign full = (lvl_ff == LVL_W'(DEPTH));
   assign empty = (lvl_ff == '0);
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      lvl_in = lvl_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10: lvl_in = lvl_ff + 1'b1;
         2'b01: lvl_in = lvl_ff - 1'b1;
         default: lvl_in = lvl_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         lvl_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         lvl_ff <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   `LK3H_ASSERT_IMP(a_no_overflow, clock, reset, full, !push)
   `LK3H_ASSERT_IMP(a_no_underflow, clock, reset, empty, !pop)

endmodule

### hdl/lk3h_back.sv
`include "lookup3_byte_stream_hash_defines.svh"
module lk3h_back (
   input logic clock,
   input logic reset,
   input lk3h_pkg::job_type head,
   input logic empty,
   output logic pop,
   input logic fin_advance,
   output logic fin_load,
   output lk3h_pkg::fin_type fin_data
);
   import lk3h_pkg::*;

   typedef enum logic {
      ST_READY,
      ST_MIX
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   abc_type abc_ff, abc_in;

   abc_type base;
   abc_type sum;

   always_comb begin
      // The first block of a message starts from the seed, later ones from the mixed words.
      base = head.load_seed ? {head.seed, head.seed, head.seed} : abc_ff;
      sum.a = base.a + head.block[31:0];
      sum.b = base.b + head.block[63:32];
      sum.c = base.c + head.block[95:64];

      fin_data.skip = (head.kind == JOB_EMPTY);
      fin_data.abc = sum;

      pop = 1'b0;
      fin_load = 1'b0;
      state_in = state_ff;
      step_in = step_ff;
      abc_in = abc_ff;

      unique case (state_ff)
         ST_READY: begin
            if (!empty) begin
               if (head.kind == JOB_MIX) begin
                  pop = 1'b1;
                  abc_in = sum;
                  step_in = '0;
                  state_in = ST_MIX;
               end else if (fin_advance) begin
                  pop = 1'b1;
                  fin_load = 1'b1;
               end
            end
         end
         ST_MIX: begin
            abc_in = bmix_step(abc_ff, step_ff);
            if (step_ff == STEP_W'(BMIX_STEPS - 1)) begin
               state_in = ST_READY;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: state_in = ST_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         abc_ff <= abc_in;
      end
   end

   `LK3H_ASSERT_IMP(a_no_pop_while_mixing, clock, reset, state_ff == ST_MIX, !pop)
   `LK3H_ASSERT_IMP(a_step_range, clock, reset, state_ff == ST_MIX, step_ff < STEP_W'(BMIX_STEPS))

endmodule

### hdl/lk3h_final.sv
`include "lookup3_byte_stream_hash_defines.svh"
module lk3h_final (
   input logic clock,
   input logic reset,
   input logic fin_load,
   input lk3h_pkg::fin_type fin_data,
   output logic advance,
   lk3h_rsp_if.source rsp_bus
);
   import lk3h_pkg::*;

   localparam int STAGES = FMIX_STEPS + 1;

   logic [STAGES-1:0] vld_ff;
   fin_type dat_ff [STAGES];

   // The whole pipeline moves together; the last stage is the output word.
   assign advance = !vld_ff[STAGES-1] || rsp_bus.ready;
   assign rsp_bus.valid = vld_ff[STAGES-1];
   assign rsp_bus.hash_value = dat_ff[STAGES-1].abc.c;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], fin_load};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dat_ff[0] <= fin_data;
         for (int k = 0; k < STAGES - 1; k++) begin
            dat_ff[k+1].skip <= dat_ff[k].skip;
            dat_ff[k+1].abc <= dat_ff[k].skip ? dat_ff[k].abc
                                              : fmix_step(dat_ff[k].abc, STEP_W'(k));
         end
      end
   end

   `LK3H_ASSERT_NXT(a_stall_holds, clock, reset, !advance, $stable(vld_ff))
   `LK3H_ASSERT_IMP(a_load_when_moving, clock, reset, fin_load, advance)

endmodule

### hdl/lookup3_byte_stream_hash.sv
// Channel   Dir  Payload                                  Handshake
// req_bus   in   byte_value, message_length, is_last      valid / ready
// rsp_bus   out  hash_value                               valid / ready
//
// One byte is taken per cycle while the job queue has room.
// After its last byte, a hash passes the job queue and then the final
// mix, a seven-stage pipeline behind the add register.
// Each full block that is followed by more bytes occupies the block-mix unit
// for one add and six rounds, once per twelve bytes.
// Reset is synchronous and clears the state, count, pointer and valid registers; no clearing pass is needed.
// A stalled rsp_bus freezes the final pipeline, then fills the queue, and then
// req_bus.ready drops.
module lookup3_byte_stream_hash #(
   parameter int QUEUE_DEPTH = lk3h_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   lk3h_req_if.sink req_bus,
   lk3h_rsp_if.source rsp_bus
);
   import lk3h_pkg::*;

   logic push;
   job_type push_data;
   logic queue_full;
   logic pop;
   job_type head;
   logic queue_empty;
   logic fin_advance;
   logic fin_load;
   fin_type fin_data;

   lk3h_front u_front (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .push(push),
      .push_data(push_data),
      .queue_full(queue_full)
   );

   lk3h_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .full(queue_full),
      .pop(pop),
      .head(head),
      .empty(queue_empty)
   );

   lk3h_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .empty(queue_empty),
      .pop(pop),
      .fin_advance(fin_advance),
      .fin_load(fin_load),
      .fin_data(fin_data)
   );

   lk3h_final u_final (
      .clock(clock),
      .reset(reset),
      .fin_load(fin_load),
      .fin_data(fin_data),
      .advance(fin_advance),
      .rsp_bus(rsp_bus)
   );

endmodule
